@@ rtl/uart_baud_divisor_calc_top_defines.svh @@
// Assertion macros shared by the baud divisor checker.
// Needs clk and rst in the scope where a macro is used.
`ifndef UART_BAUD_DIVISOR_CALC_TOP_DEFINES_SVH
`define UART_BAUD_DIVISOR_CALC_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset
`define UBDC_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ubdc check failed");

// Next-cycle implication, sampled on clk, off during reset
`define UBDC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ubdc check failed");

`endif

@@ rtl/ubdc_pkg.sv @@
// Shared types and constants for the UART baud divisor calculator.
// No dependencies.
package ubdc_pkg;

  localparam int CLK_W     = 32;  // clock_hz field
  localparam int BAUD_W    = 24;  // baud_rate field
  localparam int DIVISOR_W = 16;  // divisor field
  localparam int FRACT_W   = 3;   // fraction field

  // Oversampling factors as shift amounts (16x and 8x)
  localparam int OVER_HIGH_SH = 4;
  localparam int OVER_LOW_SH  = 3;

  // Denominator over*baud fits in baud width plus the larger shift
  localparam int DEN_W = BAUD_W + OVER_HIGH_SH;

  // Restoring divide steps per divider stage; the last stage takes the leftover steps
  localparam int STEPS_PER_STAGE = 4;

  // Per-beat control that travels down the pipe
  typedef struct packed {
    logic valid;  // stage holds a beat
    logic ovs8;   // 8x oversampling chosen
    logic bad;    // zero baud rate or divisor above maximum
  } ubdc_ctl_t;

endpackage

@@ rtl/ubdc_prep.sv @@
// First pipeline stage: oversampling choice, denominator, rounded numerator,
// overflow pre-check. Depends on ubdc_pkg.
module ubdc_prep #(
  parameter int FRAC_BITS = 3,
  parameter int QB        = 19
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          adv,
  input  logic                          req_valid,
  input  logic [ubdc_pkg::CLK_W-1:0]    clock_hz,
  input  logic [ubdc_pkg::BAUD_W-1:0]   baud_rate,
  output ubdc_pkg::ubdc_ctl_t           ctl,
  output logic [ubdc_pkg::DEN_W-1:0]    den,
  output logic [ubdc_pkg::DEN_W-1:0]    rem,
  output logic [QB-1:0]                 low
);
  import ubdc_pkg::*;

  localparam int NUM_W = QB + DEN_W;

  logic [DEN_W-1:0] den16;
  logic [DEN_W-1:0] den8;
  logic             ovs8_c;
  logic [DEN_W-1:0] den_c;
  logic [NUM_W-1:0] num_c;
  logic [DEN_W-1:0] num_hi;
  logic             bad_c;

  // 16x unless the clock is below 16 * baud
  assign den16  = {baud_rate, OVER_HIGH_SH'(0)};
  assign den8   = {1'b0, baud_rate, OVER_LOW_SH'(0)};
  assign ovs8_c = clock_hz < CLK_W'(den16);
  assign den_c  = ovs8_c ? den8 : den16;

  // clock * 2^FRAC + den/2, then quotient >= 2^QB iff num >> QB >= den
  assign num_c  = (NUM_W'(clock_hz) << FRAC_BITS) + NUM_W'(den_c >> 1);
  assign num_hi = num_c[NUM_W-1:QB];
  assign bad_c  = (baud_rate == '0) || (num_hi >= den_c);

  // Control register
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl <= '0;
    end else if (adv) begin
      ctl.valid <= req_valid;
      ctl.ovs8  <= ovs8_c;
      ctl.bad   <= bad_c;
    end
  end

  // Payload register
  always_ff @(posedge clk) begin
    if (adv) begin
      den <= den_c;
      rem <= num_hi;
      low <= num_c[QB-1:0];
    end
  end

endmodule

@@ rtl/ubdc_div_stage.sv @@
// One divider stage: a few restoring divide steps, then a register.
// Depends on ubdc_pkg.
module ubdc_div_stage #(
  parameter int QB    = 19,
  parameter int STEPS = 4
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        adv,
  input  ubdc_pkg::ubdc_ctl_t         ctl_in,
  input  logic [ubdc_pkg::DEN_W-1:0]  den_in,
  input  logic [ubdc_pkg::DEN_W-1:0]  rem_in,
  input  logic [QB-1:0]               low_in,
  input  logic [QB-1:0]               quo_in,
  output ubdc_pkg::ubdc_ctl_t         ctl,
  output logic [ubdc_pkg::DEN_W-1:0]  den,
  output logic [ubdc_pkg::DEN_W-1:0]  rem,
  output logic [QB-1:0]               low,
  output logic [QB-1:0]               quo
);
  import ubdc_pkg::*;

  logic [DEN_W-1:0] rem_next;
  logic [QB-1:0]    low_next;
  logic [QB-1:0]    quo_next;

  // Shift in one numerator bit per step, subtract when it fits
  always_comb begin
    logic [DEN_W:0]   t;
    logic [DEN_W-1:0] r;
    logic [QB-1:0]    l;
    logic [QB-1:0]    q;
    r = rem_in;
    l = low_in;
    q = quo_in;
    t = '0;
    for (int i = 0; i < STEPS; i++) begin
      t = {r, l[QB-1]};
      l = {l[QB-2:0], 1'b0};
      if (t >= {1'b0, den_in}) begin
        t = t - {1'b0, den_in};
        q = {q[QB-2:0], 1'b1};
      end else begin
        q = {q[QB-2:0], 1'b0};
      end
      r = t[DEN_W-1:0];
    end
    rem_next = r;
    low_next = l;
    quo_next = q;
  end

  // Control register
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl <= '0;
    end else if (adv) begin
      ctl <= ctl_in;
    end
  end

  // Payload register
  always_ff @(posedge clk) begin
    if (adv) begin
      den <= den_in;
      rem <= rem_next;
      low <= low_next;
      quo <= quo_next;
    end
  end

endmodule

@@ rtl/ubdc_out.sv @@
// Last stage: split quotient into divisor and fraction, range check,
// output register. Depends on ubdc_pkg.
module ubdc_out #(
  parameter int DIV_BITS  = 16,
  parameter int FRAC_BITS = 3
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            adv,
  input  ubdc_pkg::ubdc_ctl_t             ctl_in,
  input  logic [DIV_BITS+FRAC_BITS-1:0]   quo_in,
  output logic                            rsp_valid,
  output logic [ubdc_pkg::DIVISOR_W-1:0]  divisor,
  output logic [ubdc_pkg::FRACT_W-1:0]    fraction,
  output logic                            oversample_by_8,
  output logic                            rate_ok
);
  import ubdc_pkg::*;

  localparam int QB = DIV_BITS + FRAC_BITS;

  logic [DIV_BITS-1:0]           ip;
  logic [DIV_BITS+DIVISOR_W-1:0] ip_x;
  logic [FRAC_BITS+FRACT_W-1:0]  fp_x;
  logic                          ok_c;

  // Integer part must be nonzero; the upper bound was checked up front
  assign ip   = quo_in[QB-1:FRAC_BITS];
  assign ip_x = (DIV_BITS+DIVISOR_W)'(ip);
  assign fp_x = (FRAC_BITS+FRACT_W)'(quo_in[FRAC_BITS-1:0]);
  assign ok_c = !ctl_in.bad && (ip != '0);

  // Control register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (adv) begin
      rsp_valid <= ctl_in.valid;
    end
  end

  // Payload register
  always_ff @(posedge clk) begin
    if (adv) begin
      divisor         <= ok_c ? ip_x[DIVISOR_W-1:0] : '0;
      fraction        <= ok_c ? fp_x[FRACT_W-1:0] : '0;
      oversample_by_8 <= ctl_in.ovs8;
      rate_ok         <= ok_c;
    end
  end

endmodule

@@ rtl/uart_baud_divisor_calc_top.sv @@
// Channel | valid     | stall     | fields
// req     | req_valid | req_stall | clock_hz, baud_rate
// rsp     | rsp_valid | rsp_stall | divisor, fraction, oversample_by_8, rate_ok
//
// One beat in per cycle while the output beat is not stalled. The pipe is a
// prep stage, divider stages of up to four restoring steps each, and the
// output register. The whole pipe holds while the output beat is stalled;
// req_stall follows that. Synchronous reset clears the control registers only.
//
// Top level of the UART baud divisor calculator.
// Depends on ubdc_pkg, ubdc_prep, ubdc_div_stage, ubdc_out.
module uart_baud_divisor_calc_top #(
  parameter int FRAC_BITS = 3,
  parameter int DIV_BITS  = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            req_valid,
  output logic                            req_stall,
  input  logic [ubdc_pkg::CLK_W-1:0]      clock_hz,
  input  logic [ubdc_pkg::BAUD_W-1:0]     baud_rate,
  output logic                            rsp_valid,
  input  logic                            rsp_stall,
  output logic [ubdc_pkg::DIVISOR_W-1:0]  divisor,
  output logic [ubdc_pkg::FRACT_W-1:0]    fraction,
  output logic                            oversample_by_8,
  output logic                            rate_ok
);
  import ubdc_pkg::*;

  localparam int QB = DIV_BITS + FRAC_BITS;
  localparam int NS = (QB + STEPS_PER_STAGE - 1) / STEPS_PER_STAGE;

  logic adv;

  ubdc_ctl_t        ctl_s [NS+1];
  logic [DEN_W-1:0] den_s [NS+1];
  logic [DEN_W-1:0] rem_s [NS+1];
  logic [QB-1:0]    low_s [NS+1];
  logic [QB-1:0]    quo_s [NS+1];

  // Pipe moves unless the output beat is held
  assign adv       = !(rsp_valid && rsp_stall);
  assign req_stall = !adv;

  ubdc_prep #(
    .FRAC_BITS (FRAC_BITS),
    .QB        (QB)
  ) u_prep (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .req_valid (req_valid),
    .clock_hz  (clock_hz),
    .baud_rate (baud_rate),
    .ctl       (ctl_s[0]),
    .den       (den_s[0]),
    .rem       (rem_s[0]),
    .low       (low_s[0])
  );

  assign quo_s[0] = '0;

  // Divider stages; the last one takes the leftover steps
  for (genvar s = 0; s < NS; s++) begin : g_div
    localparam int LEFT  = QB - s * STEPS_PER_STAGE;
    localparam int STEPS = (LEFT < STEPS_PER_STAGE) ? LEFT : STEPS_PER_STAGE;

    ubdc_div_stage #(
      .QB    (QB),
      .STEPS (STEPS)
    ) u_stage (
      .clk    (clk),
      .rst    (rst),
      .adv    (adv),
      .ctl_in (ctl_s[s]),
      .den_in (den_s[s]),
      .rem_in (rem_s[s]),
      .low_in (low_s[s]),
      .quo_in (quo_s[s]),
      .ctl    (ctl_s[s+1]),
      .den    (den_s[s+1]),
      .rem    (rem_s[s+1]),
      .low    (low_s[s+1]),
      .quo    (quo_s[s+1])
    );
  end

  ubdc_out #(
    .DIV_BITS  (DIV_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) u_out (
    .clk             (clk),
    .rst             (rst),
    .adv             (adv),
    .ctl_in          (ctl_s[NS]),
    .quo_in          (quo_s[NS]),
    .rsp_valid       (rsp_valid),
    .divisor         (divisor),
    .fraction        (fraction),
    .oversample_by_8 (oversample_by_8),
    .rate_ok         (rate_ok)
  );

endmodule

@@ rtl/ubdc_checker.sv @@
// Port-level checks for the UART baud divisor calculator, bound to the top.
// Depends on ubdc_pkg and uart_baud_divisor_calc_top_defines.svh.
`include "uart_baud_divisor_calc_top_defines.svh"

module ubdc_checker (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            req_valid,
  input  logic                            req_stall,
  input  logic [ubdc_pkg::CLK_W-1:0]      clock_hz,
  input  logic [ubdc_pkg::BAUD_W-1:0]     baud_rate,
  input  logic                            rsp_valid,
  input  logic                            rsp_stall,
  input  logic [ubdc_pkg::DIVISOR_W-1:0]  divisor,
  input  logic [ubdc_pkg::FRACT_W-1:0]    fraction,
  input  logic                            oversample_by_8,
  input  logic                            rate_ok
);
  import ubdc_pkg::*;

  // A held output beat stays put
  `UBDC_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(divisor) && $stable(fraction) && $stable(oversample_by_8) && $stable(rate_ok))

  // Input backs up only behind a held output beat
  `UBDC_ASSERT_NOW(a_req_stall_cause, req_stall, rsp_valid && rsp_stall)

  // Out-of-range results carry zero divisor and fraction
  `UBDC_ASSERT_NOW(a_bad_zero, rsp_valid && !rate_ok, divisor == '0 && fraction == '0)

endmodule

bind uart_baud_divisor_calc_top ubdc_checker u_ubdc_checker (.*);

@@ test/testbench.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for uart_baud_divisor_calc_top: computes the expected
// divisor, fraction and oversampling mode of every accepted request beat.
// Depends on ubdc_pkg and the RTL of uart_baud_divisor_calc_top.
module testbench;
  import ubdc_pkg::*;

  localparam int FRAC_BITS = 3;
  localparam int DIV_BITS  = 16;
  localparam int PIPE_LAT  = 2 + (DIV_BITS + FRAC_BITS + 3) / 4;
  localparam int SETTLE_CYCLES  = 4 * PIPE_LAT + 10;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_REQS    = 1900;

  // One request beat plus the idle cycles placed before it
  typedef struct {
    logic [CLK_W-1:0]  clock_hz;
    logic [BAUD_W-1:0] baud_rate;
    int                gap;
    bit                drain;  // wait for all results before sending
  } baud_req_t;

  // Expected response beat
  typedef struct packed {
    logic [DIVISOR_W-1:0] divisor;
    logic [FRACT_W-1:0]   fraction;
    logic                 ovs8;
    logic                 rate_ok;
  } divisor_result_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 req_valid = 1'b0;
  logic                 req_stall;
  logic [CLK_W-1:0]     clock_hz = '0;
  logic [BAUD_W-1:0]    baud_rate = '0;
  logic                 rsp_valid;
  logic                 rsp_stall = 1'b0;
  logic [DIVISOR_W-1:0] divisor;
  logic [FRACT_W-1:0]   fraction;
  logic                 oversample_by_8;
  logic                 rate_ok;

  baud_req_t       req_pend_q[$];
  divisor_result_t divisor_exp_q[$];
  baud_req_t       cur_req;
  bit              have_cur = 1'b0;
  bit              req_took = 1'b0;
  bit              rsp_took = 1'b0;
  int              reqs_total = 0;
  int              reqs_accepted = 0;
  int              rsps_seen = 0;
  int              idle_cycles = 0;
  int              stall_left = 0;
  int              mismatches = 0;

  uart_baud_divisor_calc_top #(
    .FRAC_BITS(FRAC_BITS),
    .DIV_BITS (DIV_BITS)
  ) dut (
    .clk            (clk),
    .rst            (rst),
    .req_valid      (req_valid),
    .req_stall      (req_stall),
    .clock_hz       (clock_hz),
    .baud_rate      (baud_rate),
    .rsp_valid      (rsp_valid),
    .rsp_stall      (rsp_stall),
    .divisor        (divisor),
    .fraction       (fraction),
    .oversample_by_8(oversample_by_8),
    .rate_ok        (rate_ok)
  );

  always #4 clk = ~clk;

  // Rounded fixed-point divisor clock*2^FRAC/(over*baud), full width
  function automatic divisor_result_t predict_divisor(input logic [CLK_W-1:0] clk_hz,
                                                      input logic [BAUD_W-1:0] baud);
    logic [63:0]     clk64;
    logic [63:0]     over;
    logic [63:0]     den;
    logic [63:0]     q;
    logic [63:0]     ipart;
    logic [63:0]     fpart;
    divisor_result_t r;
    clk64 = 64'(clk_hz);
    r = '0;
    if (clk64 >= (64'(baud) << OVER_HIGH_SH)) over = 64'd1 << OVER_HIGH_SH;
    else over = 64'd1 << OVER_LOW_SH;
    r.ovs8 = (over == (64'd1 << OVER_LOW_SH));
    den = over * 64'(baud);
    if (den != 64'd0) begin
      q = ((clk64 << FRAC_BITS) + den / 2) / den;
      ipart = q >> FRAC_BITS;
      fpart = q & ((64'd1 << FRAC_BITS) - 1);
      if (ipart >= 64'd1 && ipart <= (64'd1 << DIV_BITS) - 1) begin
        r.divisor  = ipart[DIVISOR_W-1:0];
        r.fraction = fpart[FRACT_W-1:0];
        r.rate_ok  = 1'b1;
      end
    end
    return r;
  endfunction

  task automatic add_req(input logic [CLK_W-1:0] c, input logic [BAUD_W-1:0] b,
                         input bit calm, input bit drain);
    baud_req_t it;
    it.clock_hz  = c;
    it.baud_rate = b;
    it.gap       = calm ? 0 : $urandom_range(0, 3);
    it.drain     = drain;
    req_pend_q.push_back(it);
    reqs_total++;
  endtask

  // Request driver: presents queued beats after their gaps
  always @(negedge clk) begin
    logic nv;
    if (rst) begin
      req_valid <= 1'b0;
    end else if (!req_valid || req_took) begin
      nv = 1'b0;
      if (!have_cur && req_pend_q.size() > 0) begin
        cur_req = req_pend_q.pop_front();
        have_cur = 1'b1;
      end
      if (have_cur) begin
        if (cur_req.gap > 0) begin
          cur_req.gap--;
        end else if (!cur_req.drain || divisor_exp_q.size() == 0) begin
          nv = 1'b1;
          clock_hz  <= cur_req.clock_hz;
          baud_rate <= cur_req.baud_rate;
          have_cur = 1'b0;
        end
      end
      req_valid <= nv;
    end
  end

  // Response stall: random per beat, with quiet stretches
  always @(negedge clk) begin
    if (rst) begin
      rsp_stall <= 1'b0;
    end else begin
      if (rsp_took) stall_left = ((rsps_seen % 320) < 64) ? 0 : $urandom_range(0, 3);
      if (stall_left > 0) begin
        rsp_stall <= 1'b1;
        stall_left--;
      end else begin
        rsp_stall <= 1'b0;
      end
    end
  end

  // Monitor: check responses, record expectations, watchdog
  always @(posedge clk) begin
    divisor_result_t exp_r;
    req_took = 1'b0;
    rsp_took = 1'b0;
    if (!rst) begin
      if (rsp_valid && !rsp_stall) begin
        rsp_took = 1'b1;
        rsps_seen++;
        if (divisor_exp_q.size() == 0) begin
          $error("unexpected response beat: divisor %0d", divisor);
          mismatches++;
        end else begin
          exp_r = divisor_exp_q.pop_front();
          if (divisor !== exp_r.divisor) begin
            $error("divisor: expected %0d, got %0d", exp_r.divisor, divisor);
            mismatches++;
          end
          if (fraction !== exp_r.fraction) begin
            $error("fraction: expected %0d, got %0d", exp_r.fraction, fraction);
            mismatches++;
          end
          if (oversample_by_8 !== exp_r.ovs8) begin
            $error("oversample_by_8: expected %0d, got %0d", exp_r.ovs8, oversample_by_8);
            mismatches++;
          end
          if (rate_ok !== exp_r.rate_ok) begin
            $error("rate_ok: expected %0d, got %0d", exp_r.rate_ok, rate_ok);
            mismatches++;
          end
        end
      end
      if (req_valid && !req_stall) begin
        req_took = 1'b1;
        divisor_exp_q.push_back(predict_divisor(clock_hz, baud_rate));
        reqs_accepted++;
      end
      if (req_took || rsp_took) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("testbench NOT OK");
        $finish;
      end
    end
  end

  // Stimulus and end of run
  initial begin
    logic [63:0]       c64;
    logic [63:0]       tgt;
    logic [BAUD_W-1:0] b;
    int                kind;
    int                sh;
    bit                calm;

    // Directed: zero baud, range edges, mode boundary, bit patterns
    add_req(32'd0, 24'd0, 1'b0, 1'b0);
    add_req(32'hFFFF_FFFF, 24'd0, 1'b0, 1'b0);
    add_req(32'd0, 24'd1, 1'b0, 1'b0);
    add_req(32'hFFFF_FFFF, 24'd1, 1'b0, 1'b0);
    add_req(32'hFFFF_FFFF, 24'hFF_FFFF, 1'b0, 1'b0);
    add_req(32'd0, 24'hFF_FFFF, 1'b0, 1'b0);
    add_req(32'd48_000_000, 24'd115_200, 1'b0, 1'b0);
    add_req(32'd1_600_000, 24'd100_000, 1'b0, 1'b0);
    add_req(32'd1_599_999, 24'd100_000, 1'b0, 1'b0);
    add_req(32'd800_000, 24'd100_000, 1'b0, 1'b0);
    add_req(32'd799_999, 24'd100_000, 1'b0, 1'b0);
    add_req(32'd399_999, 24'd100_000, 1'b0, 1'b0);
    add_req(32'd1_048_560, 24'd1, 1'b0, 1'b0);
    add_req(32'd1_048_571, 24'd1, 1'b0, 1'b0);
    add_req(32'd1_048_572, 24'd1, 1'b0, 1'b0);
    add_req(32'd1_048_576, 24'd1, 1'b0, 1'b0);
    add_req(32'd12, 24'd1, 1'b0, 1'b0);
    add_req(32'd15, 24'd1, 1'b0, 1'b0);
    add_req(32'hAAAA_AAAA, 24'h55_5555, 1'b0, 1'b0);
    add_req(32'h5555_5555, 24'hAA_AAAA, 1'b0, 1'b0);
    add_req(32'h8000_0000, 24'h80_0000, 1'b0, 1'b0);

    // Random: mostly realistic rates, some mode edges, raw noise
    for (int i = 0; i < RANDOM_REQS; i++) begin
      calm = (i % 250) < 50;
      kind = $urandom_range(0, 9);
      b = BAUD_W'($urandom & ((1 << $urandom_range(1, BAUD_W)) - 1));
      if (b == '0) b = BAUD_W'(1);
      if (kind <= 5) begin
        tgt = 64'($urandom & ((1 << $urandom_range(1, 17)) - 1));
        sh = $urandom_range(0, 1) ? OVER_HIGH_SH : OVER_LOW_SH;
        c64 = ((64'(b) * tgt) << sh) + ($urandom % (64'(b) << sh));
        if (c64 > 64'hFFFF_FFFF) c64 = 64'($urandom);
      end else if (kind == 6) begin
        sh = $urandom_range(0, 1) ? OVER_HIGH_SH : OVER_LOW_SH;
        c64 = (64'(b) << sh) + $urandom_range(0, 2) - 1;
        if (c64 > 64'hFFFF_FFFF) c64 = 64'($urandom);
      end else if (kind <= 8) begin
        c64 = 64'($urandom);
        b = BAUD_W'($urandom);
      end else begin
        c64 = $urandom_range(0, 1) ? 64'($urandom) : 64'($urandom_range(0, 64));
        if ($urandom_range(0, 1)) b = '0;
      end
      add_req(c64[CLK_W-1:0], b, calm, (i % 700) == 0);
    end

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (reqs_accepted < reqs_total || divisor_exp_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);

    if (mismatches == 0) $display("testbench OK");
    else $display("testbench NOT OK");
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+rtl
rtl/ubdc_pkg.sv
rtl/ubdc_prep.sv
rtl/ubdc_div_stage.sv
rtl/ubdc_out.sv
rtl/uart_baud_divisor_calc_top.sv
rtl/ubdc_checker.sv
test/testbench.sv
